@@ hw/rtl/thrm_pkg.sv @@
`default_nettype none
package thrm_pkg;

   localparam int PATTERN_MAX = 1024;
   localparam int TEXT_MAX    = 1048576;
   localparam int RING_AW     = $clog2(PATTERN_MAX);
   localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
   localparam int TPOS_W      = $clog2(TEXT_MAX + 1);
   localparam int POS_W       = 20;
   localparam int CNT_W       = 21;
   localparam int HW          = 31;
   localparam int XW          = 40;

   localparam logic [CNT_W-1:0] HIT_SAT = '1;

   localparam logic ACT_PATTERN  = 1'b0;
   localparam logic ACT_TEXT     = 1'b1;
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef logic [HW-1:0] hash_type;
   typedef hash_type [2:0] hash3_type;

   localparam hash3_type P_MOD = {31'd1000000009, 31'd1000000007, 31'd1610612741};
   // floor(2^41 / p) for the quotient estimate
   localparam logic [2:0][11:0] INV = {12'd2199, 12'd2199, 12'd1365};
   // first base is applied as 173 * (h / 2) since 2 * base = p + 173
   localparam logic [2:0][7:0] MULT = {8'd31, 8'd53, 8'd173};
   localparam logic [7:0] SYM_OFS = 8'd96;

   typedef struct packed {
      logic       action;
      logic [7:0] char_value;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic             kind;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] match_count;
      logic             error;
      logic             run_end;
   } rsp_type;

   typedef struct packed {
      logic       is_text;
      logic [7:0] ch;
      logic       fin;
      hash3_type  sym;
   } qent_type;

   typedef struct packed {
      logic             is_text;
      logic             work;
      logic             drop;
      logic             chk;
      logic             fin;
      logic             err;
      logic             clr;
      logic [POS_W-1:0] pos;
   } ctl_type;

   function automatic hash_type sym_val(logic [7:0] b, hash_type p);
      if (b >= SYM_OFS) return HW'(b - SYM_OFS);
      else return p - HW'(SYM_OFS - b);
   endfunction

   function automatic hash_type mod_reduce(logic [XW-1:0] x, logic [1:0] k);
      logic [10:0] xh;
      logic [22:0] qp;
      logic [10:0] q;
      logic [41:0] qm;
      logic [32:0] r;
      xh = x[XW-1:29];
      qp = 23'(xh) * 23'(INV[k]);
      q  = qp[22:12];
      qm = 42'(q) * 42'(P_MOD[k]);
      r  = 33'(42'(x) - qm);
      // estimate is at most two short
      if (r >= 33'(P_MOD[k])) r = r - 33'(P_MOD[k]);
      if (r >= 33'(P_MOD[k])) r = r - 33'(P_MOD[k]);
      return r[HW-1:0];
   endfunction

   function automatic logic [XW-1:0] mul_base(hash_type h, logic [1:0] k);
      logic [HW:0] t;
      if (k == 2'd0) begin
         t = h[0] ? ({1'b0, h} + {1'b0, P_MOD[0]}) : {1'b0, h};
         return XW'(t[HW:1]) * XW'(MULT[0]);
      end
      return XW'(h) * XW'(MULT[k]);
   endfunction

   function automatic hash_type hash_step(hash_type h, hash_type c, logic [1:0] k);
      return mod_reduce(mul_base(h, k) + XW'(c), k);
   endfunction

   function automatic hash_type mod_sub(hash_type a, hash_type b, hash_type p);
      logic [HW:0] t;
      if (a >= b) t = {1'b0, a} - {1'b0, b};
      else t = {1'b0, a} + ({1'b0, p} - {1'b0, b});
      return t[HW-1:0];
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/thrm_front.sv @@
`default_nettype none
module thrm_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire thrm_pkg::req_type  req_data,
   output logic                    fq_valid,
   input  wire logic               fq_ready,
   output thrm_pkg::qent_type      fq_data
);
   import thrm_pkg::*;

   logic     f_v_ff, f_v_in;
   qent_type ent_ff, ent_in;

   assign req_ready = !f_v_ff || fq_ready;
   assign fq_valid  = f_v_ff;
   assign fq_data   = ent_ff;

   always_comb begin
      f_v_in = (req_valid && req_ready) || (f_v_ff && !fq_ready);
      ent_in.is_text = (req_data.action == ACT_TEXT);
      ent_in.ch      = req_data.char_value;
      ent_in.fin     = req_data.is_final;
      for (int k = 0; k < 3; k++) begin
         ent_in.sym[k] = sym_val(req_data.char_value, P_MOD[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= f_v_in;
      end
      if (req_valid && req_ready) begin
         ent_ff <= ent_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/thrm_queue.sv @@
`default_nettype none
module thrm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire thrm_pkg::qent_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output thrm_pkg::qent_type       out_data
);
   import thrm_pkg::*;

   qent_type   slot_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 3'd4);
   assign out_valid = (cnt_ff != 3'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/thrm_back.sv @@
`default_nettype none
module thrm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   output logic                     q_ready,
   input  wire thrm_pkg::qent_type  q_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output thrm_pkg::rsp_type        rsp_data
);
   import thrm_pkg::*;

   // pattern and text control state
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               tl_ff, tl_in;
   logic               done_ff, done_in;
   hash3_type          ph_ff, ph_in;
   hash3_type          pb_ff, pb_in;
   logic [RING_AW-1:0] ptr_ff, ptr_in;
   logic [TPOS_W-1:0]  tpos_ff, tpos_in;
   logic [7:0]         ring_ff [PATTERN_MAX];
   logic [7:0]         rdata_ff;
   logic [RING_AW-1:0] slot;
   logic               wr_en;

   // pipeline stages
   logic               s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   ctl_type            c1, s2_c_ff, s3_c_ff, s4_c_ff, s5_c_ff;
   hash3_type          s2_sym_ff, s3_sym_ff, s2_pb_ff;
   hash3_type          s2_ph_ff, s3_ph_ff, s4_ph_ff, s5_ph_ff;
   logic [2:0][XW-1:0] s3_x_ff, x_in;
   hash3_type          s4_c_val_ff, c_in;
   hash3_type          win_ff, win_in, h_new, s5_h_ff;
   logic [CNT_W-1:0]   hits_ff, hits_in, hits_after;

   // result buffer
   rsp_type            ob_ff [4];
   logic [1:0]         owp_ff, orp_ff;
   logic [2:0]         ocnt_ff;
   logic               adv, v1, match, summ, opop;
   rsp_type            mres, sres;

   assign adv     = (ocnt_ff <= 3'd2);
   assign q_ready = adv;
   assign v1      = q_valid && adv;

   always_comb begin
      logic               clr;
      logic [LEN_W-1:0]   len0;
      logic [TPOS_W-1:0]  tpos0;
      logic [RING_AW-1:0] ptr0;
      logic               err, inrange;
      clr   = !q_data.is_text && done_ff;
      len0  = clr ? '0 : len_ff;
      tpos0 = clr ? '0 : tpos_ff;
      ptr0  = clr ? '0 : ptr_ff;
      len_in  = len0;
      tl_in   = clr ? 1'b0 : tl_ff;
      ph_in   = ph_ff;
      pb_in   = pb_ff;
      tpos_in = tpos0;
      ptr_in  = ptr0;
      done_in = done_ff;
      wr_en   = 1'b0;
      err     = (len_ff == '0) || tl_ff;
      inrange = (tpos_ff < TPOS_W'(TEXT_MAX));
      slot    = ptr_ff - RING_AW'(len_ff);
      c1.is_text = q_data.is_text;
      c1.work    = 1'b0;
      c1.drop    = (tpos_ff >= TPOS_W'(len_ff));
      c1.chk     = ((tpos_ff + 1'b1) >= TPOS_W'(len_ff));
      c1.fin     = q_data.fin;
      c1.err     = err;
      c1.clr     = clr;
      c1.pos     = POS_W'(tpos_ff + 1'b1 - TPOS_W'(len_ff));
      if (!q_data.is_text) begin
         if (clr) begin
            ph_in = '0;
            for (int k = 0; k < 3; k++) pb_in[k] = HW'(1);
         end
         if (len0 >= LEN_W'(PATTERN_MAX)) begin
            tl_in = 1'b1;
         end else begin
            for (int k = 0; k < 3; k++) begin
               ph_in[k] = hash_step(ph_in[k], q_data.sym[k], 2'(k));
               pb_in[k] = hash_step(pb_in[k], '0, 2'(k));
            end
            len_in = len0 + 1'b1;
         end
         done_in = q_data.fin;
      end else begin
         done_in = 1'b1;
         c1.work = inrange && !err;
         if (c1.work) begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
         if (inrange) tpos_in = tpos_ff + 1'b1;
         if (q_data.fin) begin
            ptr_in  = '0;
            tpos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= ring_ff[slot];
         if (v1 && wr_en) ring_ff[ptr_ff] <= q_data.ch;
      end
   end

   // drop term: (old - 96) * base^len, kept non-negative by adding 96 * p
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         x_in[k] = XW'(rdata_ff) * XW'(s2_pb_ff[k])
                 + XW'(SYM_OFS) * XW'(P_MOD[k] - s2_pb_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_in[k] = s3_c_ff.drop ?
                   mod_sub(s3_sym_ff[k], mod_reduce(s3_x_ff[k], 2'(k)), P_MOD[k]) :
                   s3_sym_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h_new[k] = hash_step(win_ff[k], s4_c_val_ff[k], 2'(k));
      end
      win_in = win_ff;
      if (s4_v_ff) begin
         if (s4_c_ff.clr) win_in = '0;
         else if (s4_c_ff.work) win_in = h_new;
         if (s4_c_ff.is_text && s4_c_ff.fin) win_in = '0;
      end
   end

   always_comb begin
      match = s5_v_ff && s5_c_ff.work && s5_c_ff.chk && (s5_h_ff == s5_ph_ff);
      summ  = s5_v_ff && s5_c_ff.is_text && s5_c_ff.fin;
      hits_after = (match && hits_ff != HIT_SAT) ? hits_ff + 1'b1 : hits_ff;
      hits_in = hits_ff;
      if (s5_v_ff) begin
         hits_in = hits_after;
         if (s5_c_ff.clr || summ) hits_in = '0;
      end
      mres.kind        = KIND_MATCH;
      mres.position    = s5_c_ff.pos;
      mres.match_count = '0;
      mres.error       = 1'b0;
      mres.run_end     = !s5_c_ff.fin;
      sres.kind        = KIND_SUMMARY;
      sres.position    = '0;
      sres.match_count = hits_after;
      sres.error       = s5_c_ff.err;
      sres.run_end     = 1'b1;
   end

   assign opop      = rsp_valid && rsp_ready;
   assign rsp_valid = (ocnt_ff != 3'd0);
   assign rsp_data  = ob_ff[orp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         tl_ff   <= 1'b0;
         done_ff <= 1'b0;
         ptr_ff  <= '0;
         tpos_ff <= '0;
         ph_ff   <= '0;
         for (int k = 0; k < 3; k++) pb_ff[k] <= HW'(1);
         win_ff  <= '0;
         hits_ff <= '0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         if (v1) begin
            len_ff  <= len_in;
            tl_ff   <= tl_in;
            done_ff <= done_in;
            ptr_ff  <= ptr_in;
            tpos_ff <= tpos_in;
            ph_ff   <= ph_in;
            pb_ff   <= pb_in;
         end
         win_ff  <= win_in;
         hits_ff <= hits_in;
         s2_v_ff <= v1;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_c_ff     <= c1;
         s2_sym_ff   <= q_data.sym;
         s2_pb_ff    <= pb_ff;
         s2_ph_ff    <= ph_ff;
         s3_c_ff     <= s2_c_ff;
         s3_sym_ff   <= s2_sym_ff;
         s3_ph_ff    <= s2_ph_ff;
         s3_x_ff     <= x_in;
         s4_c_ff     <= s3_c_ff;
         s4_ph_ff    <= s3_ph_ff;
         s4_c_val_ff <= c_in;
         s5_c_ff     <= s4_c_ff;
         s5_ph_ff    <= s4_ph_ff;
         s5_h_ff     <= h_new;
      end
   end

   // result buffer takes up to two beats a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         owp_ff  <= owp_ff + 2'((adv && match) ? 1 : 0) + 2'((adv && summ) ? 1 : 0);
         orp_ff  <= opop ? orp_ff + 2'd1 : orp_ff;
         ocnt_ff <= ocnt_ff + 3'(adv && match) + 3'(adv && summ) - 3'(opop);
      end
      if (adv) begin
         if (match) ob_ff[owp_ff] <= mres;
         if (summ) ob_ff[match ? owp_ff + 2'd1 : owp_ff] <= sres;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/triple_hash_rolling_matcher.sv @@
`default_nettype none
// a byte goes through the front register, the queue, stages s2 to s5 and the result buffer
// throughput: one byte per cycle while the result buffer holds at most two beats, set by
// the combinational hash update (multiply by base, modular reduce); a byte may add two beats
// reset clears all control state; the window ring is not cleared
module triple_hash_rolling_matcher (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire thrm_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output thrm_pkg::rsp_type       rsp_data
);
   import thrm_pkg::*;

   logic     fq_valid, fq_ready, bq_valid, bq_ready;
   qent_type fq_data, bq_data;

   thrm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .fq_valid  (fq_valid),
      .fq_ready  (fq_ready),
      .fq_data   (fq_data)
   );

   thrm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   thrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (bq_valid),
      .q_ready   (bq_ready),
      .q_data    (bq_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
   import thrm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   triple_hash_rolling_matcher uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // matcher mirror
   localparam longint unsigned BASES [3] = '{64'd805306457, 64'd53, 64'd31};
   localparam longint unsigned MODS  [3] = '{64'd1610612741, 64'd1000000007, 64'd1000000009};

   logic [HW-1:0]      pat_hash [3];
   logic [HW-1:0]      win_hash [3];
   logic [HW-1:0]      pow_top  [3];
   logic [LEN_W-1:0]   pat_len;
   logic [7:0]         ring [PATTERN_MAX];
   logic [RING_AW-1:0] wr_ptr;
   logic [TPOS_W-1:0]  txt_pos;
   logic [CNT_W-1:0]   hit_cnt;
   logic               pat_over;
   logic               pat_done;

   req_type byte_queue [$];
   rsp_type want_queue [$];
   int errors = 0;
   int accepted = 0;

   function automatic longint unsigned sym(logic [7:0] b, int k);
      return (longint'(b) + MODS[k] - 96) % MODS[k];
   endfunction

   function automatic void clear_text();
      for (int k = 0; k < 3; k++) win_hash[k] = '0;
      wr_ptr = '0;
      txt_pos = '0;
      hit_cnt = '0;
   endfunction

   function automatic void clear_pattern();
      for (int k = 0; k < 3; k++) begin
         pat_hash[k] = '0;
         pow_top[k] = HW'(1);
      end
      pat_len = '0;
      pat_over = 1'b0;
      pat_done = 1'b0;
   endfunction

   function automatic void predict_beat(req_type r);
      logic bad;
      logic same;
      longint unsigned dropv;
      rsp_type o;
      if (r.action == ACT_PATTERN) begin
         if (pat_done) begin
            clear_pattern();
            clear_text();
         end
         if (pat_len >= PATTERN_MAX) pat_over = 1'b1;
         else begin
            for (int k = 0; k < 3; k++) begin
               if (pat_len > 0)
                  pow_top[k] = HW'((longint'(pow_top[k]) * BASES[k]) % MODS[k]);
               pat_hash[k] = HW'((longint'(pat_hash[k]) * BASES[k]
                                  + sym(r.char_value, k)) % MODS[k]);
            end
            pat_len++;
         end
         if (r.is_final) pat_done = 1'b1;
         return;
      end
      pat_done = 1'b1;
      bad = (pat_len == 0) || pat_over;
      if (txt_pos < TEXT_MAX) begin
         if (!bad) begin
            if (txt_pos >= pat_len) begin
               for (int k = 0; k < 3; k++) begin
                  dropv = (sym(ring[RING_AW'(wr_ptr - pat_len)], k) * pow_top[k]) % MODS[k];
                  win_hash[k] = HW'((longint'(win_hash[k]) + MODS[k] - dropv) % MODS[k]);
               end
            end
            for (int k = 0; k < 3; k++)
               win_hash[k] = HW'((longint'(win_hash[k]) * BASES[k]
                                  + sym(r.char_value, k)) % MODS[k]);
            ring[wr_ptr] = r.char_value;
            wr_ptr++;
            if (txt_pos + 1 >= pat_len) begin
               same = 1'b1;
               for (int k = 0; k < 3; k++) if (win_hash[k] != pat_hash[k]) same = 1'b0;
               if (same) begin
                  o.kind = KIND_MATCH;
                  o.position = POS_W'(txt_pos + 1 - pat_len);
                  o.match_count = '0;
                  o.error = 1'b0;
                  o.run_end = !r.is_final;
                  want_queue = {want_queue, o};
                  if (hit_cnt < HIT_SAT) hit_cnt++;
               end
            end
         end
         txt_pos++;
      end
      if (r.is_final) begin
         o.kind = KIND_SUMMARY;
         o.position = '0;
         o.match_count = hit_cnt;
         o.error = bad;
         o.run_end = 1'b1;
         want_queue = {want_queue, o};
         clear_text();
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at beat %0d: %s", accepted, what);
      errors++;
   endtask

   // stimulus helpers
   task automatic put(logic act, logic [7:0] ch, logic fin);
      req_type r;
      r.action = act;
      r.char_value = ch;
      r.is_final = fin;
      byte_queue = {byte_queue, r};
   endtask

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 99) < 85) return 8'h61 + 8'($urandom_range(0, 1));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic put_pattern(int n, logic fin);
      for (int i = 0; i < n; i++) put(ACT_PATTERN, pick_char(), fin && (i == n - 1));
   endtask

   task automatic put_text(int n, logic fin);
      for (int i = 0; i < n; i++) put(ACT_TEXT, pick_char(), fin && (i == n - 1));
   endtask

   // driver
   req_type cur_beat;
   logic    have_beat = 1'b0;
   logic    req_taken = 1'b0;
   int      req_gap = 0;
   logic    req_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            have_beat = 1'b0;
         end
         if (!have_beat && byte_queue.size() > 0) begin
            cur_beat = byte_queue.pop_front();
            have_beat = 1'b1;
            if ($urandom_range(0, 39) == 0) req_burst = ~req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 11);
         end
         if (have_beat && req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (have_beat) begin
            req_valid <= 1'b1;
            req_data <= cur_beat;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         predict_beat(req_data);
         req_taken = 1'b1;
         accepted++;
      end
   end

   // receiver
   int   rsp_gap = 0;
   int   long_hold = 0;
   logic long_done = 1'b0;
   logic rsp_taken = 1'b0;
   logic rsp_burst = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 29) == 0) rsp_burst = ~rsp_burst;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, 11);
         end
         if (!long_done && accepted >= 300) begin
            long_done = 1'b1;
            long_hold = 400;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (want_queue.size() == 0) report_mismatch("result with nothing expected");
         else begin
            w = want_queue.pop_front();
            if (rsp_data.kind != w.kind) report_mismatch("kind");
            if (rsp_data.position != w.position) report_mismatch("position");
            if (rsp_data.match_count != w.match_count) report_mismatch("match_count");
            if (rsp_data.error != w.error) report_mismatch("error");
            if (rsp_data.run_end != w.run_end) report_mismatch("run_end");
         end
      end
   end

   int cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int mode;
      clear_pattern();
      clear_text();
      for (int i = 0; i < PATTERN_MAX; i++) ring[i] = '0;

      // text with no pattern yet: empty pattern error
      put(ACT_TEXT, 8'h61, 1'b0);
      put(ACT_TEXT, 8'h00, 1'b1);
      put(ACT_PATTERN, 8'h61, 1'b0);
      put(ACT_PATTERN, 8'h62, 1'b1);
      put(ACT_TEXT, 8'h61, 1'b0);
      put(ACT_TEXT, 8'h62, 1'b0);
      put(ACT_TEXT, 8'h61, 1'b0);
      put(ACT_TEXT, 8'h62, 1'b1);
      // extreme bytes
      put(ACT_PATTERN, 8'hff, 1'b1);
      put(ACT_TEXT, 8'hff, 1'b0);
      put(ACT_TEXT, 8'h00, 1'b0);
      put(ACT_TEXT, 8'hff, 1'b1);
      put(ACT_PATTERN, 8'h00, 1'b1);
      put(ACT_TEXT, 8'h00, 1'b0);
      put(ACT_TEXT, 8'h00, 1'b1);
      // new pattern drops the text in progress
      put(ACT_TEXT, 8'h00, 1'b0);
      put(ACT_PATTERN, 8'h62, 1'b0);
      // text before the pattern is final
      put(ACT_TEXT, 8'h62, 1'b0);
      put(ACT_TEXT, 8'h62, 1'b1);
      // same pattern kept for the next text
      put(ACT_TEXT, 8'h62, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() + accepted < 500) begin
         mode = $urandom_range(0, 9);
         if (mode == 0) begin
            put_pattern($urandom_range(1, 5), 1'b0);
            put_text($urandom_range(3, 30), 1'b1);
         end else if (mode == 1) begin
            put_pattern($urandom_range(1, 5), 1'b1);
            put_text($urandom_range(1, 20), 1'b0);
         end else begin
            put_pattern($urandom_range(1, 5), 1'b1);
            put_text($urandom_range(5, 40), 1'b1);
            if ($urandom_range(0, 2) == 0) put_text($urandom_range(1, 15), 1'b1);
         end
         while (byte_queue.size() > 200) @(posedge clock);
      end

      // overlong pattern, then texts that can never match
      put_pattern(PATTERN_MAX + 6, 1'b1);
      put_text(8, 1'b1);
      put_text(3, 1'b1);

      wait (byte_queue.size() == 0 && !have_beat);
      wait (want_queue.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && want_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
